>>> rtl/core/ufr_pkg.sv
package ufr_pkg;

    // Frame sync pattern
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // Replacement for zero payload bytes on readout
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Register reset values
    localparam logic [7:0] MATCH_CLASS_RESET = 8'h0A;
    localparam logic [7:0] MATCH_ID_RESET    = 8'h04;

    // Register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_CLASS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID    = 1'b1;

    // Default sizing
    localparam int unsigned PAYLOAD_DEPTH_DEF = 128;
    localparam int unsigned MODEL_BYTES_DEF   = 63;

endpackage

>>> rtl/core/ubx_frame_receiver_top.sv
// Channel   Direction  Handshake                      Payload
// -------   ---------  -----------------------------  ---------------------------
// rx        in         i_rx_valid / o_rx_ready        i_rx_byte
// out       out        o_out_valid / i_out_ready      o_model_byte, o_last
// cfg       in         i_cfg_we (write only)          i_cfg_index, i_cfg_data
//
// For each received byte the parser updates its checksum, length and index
// registers and writes payload bytes into the payload RAM. After a good frame
// the payload RAM is read back: each result byte is read from the synchronous
// RAM, then loaded into the output register; rx is held off during readout.
// Reset (i_rst_n low, synchronous) returns the parser to hunting, clears the
// output register valid and restores the match registers; the RAM is not
// cleared, since only bytes written by the current frame are ever read.
// A stalled output holds the readout; the last result byte may still wait in
// the output register while hunting for the next frame has already resumed.
module ubx_frame_receiver_top #(
    parameter int unsigned PAYLOAD_DEPTH = ufr_pkg::PAYLOAD_DEPTH_DEF,
    parameter int unsigned MODEL_BYTES   = ufr_pkg::MODEL_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_rx_valid,
    output logic                          o_rx_ready,
    input  logic [7:0]                    i_rx_byte,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_model_byte,
    output logic                          o_last,

    input  logic                          i_cfg_we,
    input  logic [ufr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    // RAM address, payload byte counter and readout counter widths
    localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int unsigned IW = $clog2(PAYLOAD_DEPTH + 1);
    localparam int unsigned CW = $clog2(MODEL_BYTES + 1);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B,
        PH_EMIT_RD,
        PH_EMIT_LD
    } t_phase;

    // Payload RAM: one write port (parser), one read port (readout)
    logic [7:0] r_payload_mem [PAYLOAD_DEPTH];
    logic [7:0] r_rd_data;
    logic       mem_we;
    logic       mem_re;
    logic [AW-1:0] mem_wr_addr;
    logic [AW-1:0] mem_rd_addr;

    t_phase     r_phase,       n_phase;
    logic [7:0] r_match_class, n_match_class;
    logic [7:0] r_match_id,    n_match_id;
    logic [7:0] r_sum_a,       n_sum_a;
    logic [7:0] r_sum_b,       n_sum_b;
    logic [15:0] r_frame_len,  n_frame_len;
    logic [IW-1:0] r_byte_idx, n_byte_idx;
    logic [CW-1:0] r_emit_idx, n_emit_idx;
    logic [CW-1:0] r_emit_cnt, n_emit_cnt;
    logic       r_out_valid,   n_out_valid;
    logic [7:0] r_model_byte,  n_model_byte;
    logic       r_last,        n_last;

    logic       rx_xfer;
    logic       out_free;
    logic       emit_last;
    logic [7:0] sum_a_add;
    logic [7:0] sum_b_add;
    logic [15:0] len_full;

    assign o_rx_ready   = (r_phase != PH_EMIT_RD) && (r_phase != PH_EMIT_LD);
    assign rx_xfer      = i_rx_valid && o_rx_ready;
    assign out_free     = !r_out_valid || i_out_ready;
    assign emit_last    = (CW'(r_emit_idx + CW'(1)) == r_emit_cnt);

    // Running checksum with the current byte folded in
    assign sum_a_add = r_sum_a + i_rx_byte;
    assign sum_b_add = r_sum_b + sum_a_add;
    assign len_full  = {i_rx_byte, r_frame_len[7:0]};

    assign mem_wr_addr = AW'(r_byte_idx);
    assign mem_rd_addr = AW'(r_emit_idx);
    assign mem_we      = rx_xfer && (r_phase == PH_PAYLOAD);
    assign mem_re      = (r_phase == PH_EMIT_RD);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_payload_mem[mem_wr_addr] <= i_rx_byte;
        end
        if (mem_re) begin
            r_rd_data <= r_payload_mem[mem_rd_addr];
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_match_class = r_match_class;
        n_match_id    = r_match_id;
        n_sum_a       = r_sum_a;
        n_sum_b       = r_sum_b;
        n_frame_len   = r_frame_len;
        n_byte_idx    = r_byte_idx;
        n_emit_idx    = r_emit_idx;
        n_emit_cnt    = r_emit_cnt;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_model_byte  = r_model_byte;
        n_last        = r_last;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                ufr_pkg::REG_MATCH_CLASS: n_match_class = i_cfg_data;
                ufr_pkg::REG_MATCH_ID:    n_match_id    = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_phase)
            PH_SYNC2: begin
                if (rx_xfer) begin
                    n_phase = (i_rx_byte == ufr_pkg::SYNC_SECOND) ? PH_CLASS : PH_HUNT;
                end
            end
            PH_CLASS: begin
                if (rx_xfer) begin
                    // Restart the checksum on the class byte
                    n_sum_a = i_rx_byte;
                    n_sum_b = i_rx_byte;
                    n_phase = (i_rx_byte == r_match_class) ? PH_ID : PH_HUNT;
                end
            end
            PH_ID: begin
                if (rx_xfer) begin
                    n_sum_a = sum_a_add;
                    n_sum_b = sum_b_add;
                    n_phase = (i_rx_byte == r_match_id) ? PH_LEN_LO : PH_HUNT;
                end
            end
            PH_LEN_LO: begin
                if (rx_xfer) begin
                    n_sum_a     = sum_a_add;
                    n_sum_b     = sum_b_add;
                    n_frame_len = {8'h00, i_rx_byte};
                    n_byte_idx  = '0;
                    n_phase     = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                if (rx_xfer) begin
                    n_sum_a     = sum_a_add;
                    n_sum_b     = sum_b_add;
                    n_frame_len = len_full;
                    n_byte_idx  = '0;
                    // Drop empty frames and frames that overflow the RAM
                    if ((len_full == 16'd0) || (len_full > 16'(PAYLOAD_DEPTH))) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (rx_xfer) begin
                    n_sum_a    = sum_a_add;
                    n_sum_b    = sum_b_add;
                    n_byte_idx = IW'(r_byte_idx + IW'(1));
                    if ((16'(r_byte_idx) + 16'd1) == r_frame_len) begin
                        n_phase = PH_CK_A;
                    end
                end
            end
            PH_CK_A: begin
                if (rx_xfer) begin
                    n_phase = (i_rx_byte == r_sum_a) ? PH_CK_B : PH_HUNT;
                end
            end
            PH_CK_B: begin
                if (rx_xfer) begin
                    if (i_rx_byte == r_sum_b) begin
                        n_emit_idx = '0;
                        n_emit_cnt = (r_frame_len > 16'(MODEL_BYTES)) ?
                                     CW'(MODEL_BYTES) : r_frame_len[CW-1:0];
                        n_phase    = PH_EMIT_RD;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            PH_EMIT_RD: begin
                n_phase = PH_EMIT_LD;
            end
            PH_EMIT_LD: begin
                // Hold the RAM data until the output register frees up
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_model_byte = (r_rd_data == 8'h00) ? ufr_pkg::SPACE_CHAR : r_rd_data;
                    n_last       = emit_last;
                    if (emit_last) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_emit_idx = CW'(r_emit_idx + CW'(1));
                        n_phase    = PH_EMIT_RD;
                    end
                end
            end
            default: begin
                if (rx_xfer) begin
                    n_phase = (i_rx_byte == ufr_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_match_class <= ufr_pkg::MATCH_CLASS_RESET;
            r_match_id    <= ufr_pkg::MATCH_ID_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_match_class <= n_match_class;
            r_match_id    <= n_match_id;
            r_out_valid   <= n_out_valid;
        end
        r_sum_a      <= n_sum_a;
        r_sum_b      <= n_sum_b;
        r_frame_len  <= n_frame_len;
        r_byte_idx   <= n_byte_idx;
        r_emit_idx   <= n_emit_idx;
        r_emit_cnt   <= n_emit_cnt;
        r_model_byte <= n_model_byte;
        r_last       <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_model_byte = r_model_byte;
    assign o_last       = r_last;

    // A RAM read is always followed by its load cycle
    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EMIT_RD) |=> (r_phase == PH_EMIT_LD))
        else $error("readout skipped the load cycle");

    // Readout index stays inside the result count
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_EMIT_RD) || (r_phase == PH_EMIT_LD)) |->
        (r_emit_idx < r_emit_cnt))
        else $error("readout index past result count");

    // Payload writes stay below the frame length
    a_payload_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (16'(r_byte_idx) < r_frame_len))
        else $error("payload index past frame length");

    // Loading the last byte ends the readout
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_EMIT_LD) && out_free && emit_last) |=>
        ((r_phase == PH_HUNT) && r_out_valid && r_last))
        else $error("readout did not end after last byte");

    // No payload write while the readout runs
    a_rx_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_EMIT_RD) || (r_phase == PH_EMIT_LD)) |-> !mem_we)
        else $error("payload write during readout");

endmodule

>>> sim/ubx_frame_receiver_top_test.sv
`timescale 1ns / 1ps

module ubx_frame_receiver_top_test;

    localparam int unsigned PAYLOAD_DEPTH = ufr_pkg::PAYLOAD_DEPTH_DEF;
    localparam int unsigned MODEL_BYTES   = ufr_pkg::MODEL_BYTES_DEF;

    // Parser phases of the frame tracker, one per field of the frame
    typedef enum logic [3:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        READ_CLASS,
        READ_ID,
        READ_LEN_LO,
        READ_LEN_HI,
        READ_PAYLOAD,
        READ_CK_A,
        READ_CK_B
    } t_parse_phase;

    // Shapes of random byte sequences; everything past SEQ_GOOD is broken on purpose
    typedef enum int {
        SEQ_GOOD,
        SEQ_NOISE,
        SEQ_BAD_SYNC,
        SEQ_BAD_CLASS,
        SEQ_BAD_ID,
        SEQ_ZERO_LEN,
        SEQ_OVERSIZE,
        SEQ_BAD_CK_A,
        SEQ_BAD_CK_B,
        SEQ_TRUNCATED
    } t_seq_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_payload_char;

    // One directed row: the byte to send and, where obvious, the single result it yields
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic [7:0] exp_data;
        logic       exp_last;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 24;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // second sync byte is 0xB5 again: back to hunting
        '{8'hB5, 1'b0, 8'h00, 1'b0}, '{8'hB5, 1'b0, 8'h00, 1'b0},
        // class all ones: wrong class
        '{8'hB5, 1'b0, 8'h00, 1'b0}, '{8'h62, 1'b0, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 8'h00, 1'b0},
        // ID all zeros: wrong ID
        '{8'hB5, 1'b0, 8'h00, 1'b0}, '{8'h62, 1'b0, 8'h00, 1'b0},
        '{8'h0A, 1'b0, 8'h00, 1'b0}, '{8'h00, 1'b0, 8'h00, 1'b0},
        // length 0xFFFF: oversized
        '{8'hB5, 1'b0, 8'h00, 1'b0}, '{8'h62, 1'b0, 8'h00, 1'b0},
        '{8'h0A, 1'b0, 8'h00, 1'b0}, '{8'h04, 1'b0, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 8'h00, 1'b0}, '{8'hFF, 1'b0, 8'h00, 1'b0},
        // good one-byte frame carrying a zero byte: comes out as a space, marked last
        '{8'hB5, 1'b0, 8'h00, 1'b0}, '{8'h62, 1'b0, 8'h00, 1'b0},
        '{8'h0A, 1'b0, 8'h00, 1'b0}, '{8'h04, 1'b0, 8'h00, 1'b0},
        '{8'h01, 1'b0, 8'h00, 1'b0}, '{8'h00, 1'b0, 8'h00, 1'b0},
        '{8'h00, 1'b0, 8'h00, 1'b0}, '{8'h0F, 1'b0, 8'h00, 1'b0},
        '{8'h45, 1'b1, 8'h20, 1'b1}
    };

    logic                          i_clk;
    logic                          i_rst_n      = 1'b0;
    logic                          i_rx_valid   = 1'b0;
    logic                          o_rx_ready;
    logic [7:0]                    i_rx_byte    = 8'h00;
    logic                          o_out_valid;
    logic                          i_out_ready  = 1'b0;
    logic [7:0]                    o_model_byte;
    logic                          o_last;
    logic                          i_cfg_we     = 1'b0;
    logic [ufr_pkg::CFG_IDX_W-1:0] i_cfg_index  = ufr_pkg::REG_MATCH_CLASS;
    logic [7:0]                    i_cfg_data   = 8'h00;

    ubx_frame_receiver_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_model_byte (o_model_byte),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Frame tracker state, kept by the bench from the sent bytes to model the block
    t_parse_phase  pr_phase;
    logic [7:0]    pr_sum_a;
    logic [7:0]    pr_sum_b;
    logic [15:0]   pr_len;
    logic [7:0]    pr_idx;
    logic [7:0]    pr_store [PAYLOAD_DEPTH];
    logic [7:0]    match_cls;
    logic [7:0]    match_mid;

    // Payload bytes still owed by the block, oldest first
    t_payload_char pending_payload [$];

    int            mismatches    = 0;
    int            rx_sent       = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Fold one byte into the two running checksum sums
    task automatic fold_byte(input logic [7:0] b);
        pr_sum_a = pr_sum_a + b;
        pr_sum_b = pr_sum_b + pr_sum_a;
    endtask

    // Advance the frame tracker by one accepted byte; queue the payload
    // readout of a good frame unless the caller supplies it by hand
    task automatic track_rx_byte(input logic [7:0] b, input bit keep);
        int            n;
        t_payload_char ch;
        case (pr_phase)
            HUNT_SYNC2: pr_phase = (b == ufr_pkg::SYNC_SECOND) ? READ_CLASS : HUNT_SYNC1;
            READ_CLASS: begin
                pr_sum_a = 8'h00;
                pr_sum_b = 8'h00;
                fold_byte(b);
                pr_phase = (b == match_cls) ? READ_ID : HUNT_SYNC1;
            end
            READ_ID: begin
                fold_byte(b);
                pr_phase = (b == match_mid) ? READ_LEN_LO : HUNT_SYNC1;
            end
            READ_LEN_LO: begin
                fold_byte(b);
                pr_len   = {8'h00, b};
                pr_idx   = 8'h00;
                pr_phase = READ_LEN_HI;
            end
            READ_LEN_HI: begin
                fold_byte(b);
                pr_len[15:8] = b;
                pr_idx       = 8'h00;
                pr_phase     = (pr_len == 16'h0000 || pr_len > PAYLOAD_DEPTH) ?
                               HUNT_SYNC1 : READ_PAYLOAD;
            end
            READ_PAYLOAD: begin
                fold_byte(b);
                if (pr_idx < pr_len && pr_idx < PAYLOAD_DEPTH) begin
                    pr_store[pr_idx] = b;
                    pr_idx++;
                end
                if (pr_idx >= pr_len) begin
                    pr_phase = READ_CK_A;
                end
            end
            // A bad CK_A drops the frame at once; CK_B is then just a hunted byte
            READ_CK_A: pr_phase = (b == pr_sum_a) ? READ_CK_B : HUNT_SYNC1;
            READ_CK_B: begin
                pr_phase = HUNT_SYNC1;
                if (b == pr_sum_b && pr_len != 16'h0000) begin
                    n = (pr_len > MODEL_BYTES) ? MODEL_BYTES : int'(pr_len);
                    for (int k = 0; k < n; k++) begin
                        ch.data = (pr_store[k] == 8'h00) ? ufr_pkg::SPACE_CHAR : pr_store[k];
                        ch.last = (k == n - 1);
                        if (keep) begin
                            pending_payload.push_back(ch);
                        end
                    end
                end
            end
            default: pr_phase = (b == ufr_pkg::SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
        endcase
    endtask

    // Offer one byte, idling first at the current sender rate; return at its transfer
    task automatic send_byte(input logic [7:0] b, input bit keep);
        if ($urandom_range(99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        rx_sent++;
        track_rx_byte(b, keep);
    endtask

    // Drop valid, hold until every payload byte is out, then let the parser settle
    task automatic drain();
        i_rx_valid <= 1'b0;
        while (pending_payload.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write both match registers on consecutive edges
    task automatic write_match(input logic [7:0] cls, input logic [7:0] mid);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ufr_pkg::REG_MATCH_CLASS;
        i_cfg_data  <= cls;
        @(posedge i_clk);
        match_cls = cls;
        i_cfg_index <= ufr_pkg::REG_MATCH_ID;
        i_cfg_data  <= mid;
        @(posedge i_clk);
        match_mid = mid;
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 75) begin
            return $urandom_range(6, 1);
        end else if (r < 95) begin
            return $urandom_range(20, 7);
        end
        return $urandom_range(MODEL_BYTES + 3, MODEL_BYTES - 3);
    endfunction

    // Build one frame for the current match values, break it as asked, and send it
    task automatic send_sequence(input t_seq_kind kind, input int plen);
        logic [7:0]  cls;
        logic [7:0]  mid;
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic [15:0] len;
        logic [7:0]  q [$];
        int          keep;
        cls = match_cls;
        mid = match_mid;
        len = 16'(plen);
        case (kind)
            SEQ_BAD_CLASS: cls = cls ^ 8'($urandom_range(255, 1));
            SEQ_BAD_ID:    mid = mid ^ 8'($urandom_range(255, 1));
            SEQ_ZERO_LEN:  len = 16'h0000;
            SEQ_OVERSIZE:  len = 16'($urandom_range(16'hFFFF, PAYLOAD_DEPTH + 1));
            default: ;
        endcase
        if (kind == SEQ_NOISE) begin
            // lean on sync bytes so half-started frames show up often
            repeat ($urandom_range(4, 1)) begin
                q.push_back($urandom_range(1) ? ufr_pkg::SYNC_FIRST :
                            8'($urandom_range(255)));
            end
            keep = q.size();
        end else begin
            q = '{ufr_pkg::SYNC_FIRST, ufr_pkg::SYNC_SECOND, cls, mid, len[7:0], len[15:8]};
            case (kind)
                SEQ_BAD_SYNC: begin
                    q[1] = $urandom_range(1) ? ufr_pkg::SYNC_FIRST :
                           (ufr_pkg::SYNC_SECOND ^ 8'($urandom_range(255, 1)));
                    keep = 2;
                end
                SEQ_BAD_CLASS:              keep = 3;
                SEQ_BAD_ID:                 keep = 4;
                SEQ_ZERO_LEN, SEQ_OVERSIZE: keep = 6;
                default: begin
                    repeat (len) begin
                        q.push_back(($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255)));
                    end
                    ck_a = 8'h00;
                    ck_b = 8'h00;
                    for (int i = 2; i < q.size(); i++) begin
                        ck_a = ck_a + q[i];
                        ck_b = ck_b + ck_a;
                    end
                    if (kind == SEQ_BAD_CK_A) begin
                        ck_a = ck_a ^ 8'($urandom_range(255, 1));
                    end
                    if (kind == SEQ_BAD_CK_B) begin
                        ck_b = ck_b ^ 8'($urandom_range(255, 1));
                    end
                    q.push_back(ck_a);
                    q.push_back(ck_b);
                    // a cut frame leaves the parser mid-frame; later bytes fill it up
                    keep = (kind == SEQ_TRUNCATED) ? $urandom_range(q.size() - 1, 3) : q.size();
                end
            endcase
        end
        foreach (q[i]) begin
            if (i < keep) begin
                send_byte(q[i], 1'b1);
            end
        end
    endtask

    // Output side: check each transfer against the oldest owed byte, then pick
    // the next ready at the current receiver rate
    always @(posedge i_clk) begin : out_monitor
        t_payload_char due;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_payload.size() == 0) begin
                $error("unexpected transfer: model_byte %h last %b", o_model_byte, o_last);
                mismatches++;
            end else begin
                due = pending_payload.pop_front();
                if (o_model_byte !== due.data) begin
                    $error("model_byte mismatch: expected %h, actual %h", due.data, o_model_byte);
                    mismatches++;
                end
                if (o_last !== due.last) begin
                    $error("last mismatch: expected %b, actual %b", due.last, o_last);
                    mismatches++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin : stimulus
        t_seq_kind kind;
        int        plen;
        int        seg_start;
        int        forced;
        // Reset the tracker along with the block
        pr_phase  = HUNT_SYNC1;
        pr_sum_a  = 8'h00;
        pr_sum_b  = 8'h00;
        pr_len    = 16'h0000;
        pr_idx    = 8'h00;
        match_cls = ufr_pkg::MATCH_CLASS_RESET;
        match_mid = ufr_pkg::MATCH_ID_RESET;

        send_idle_pct = 22;
        recv_idle_pct = 53;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset match values
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_byte(DIRECTED[r].rx, !DIRECTED[r].typed);
            if (DIRECTED[r].typed) begin
                pending_payload.push_back('{data: DIRECTED[r].exp_data,
                                            last: DIRECTED[r].exp_last});
            end
        end

        // Random part: six stretches, each with its own match values; the
        // idling swaps sides after two stretches and stops after four
        for (int seg = 0; seg < 6; seg++) begin
            drain();
            case (seg)
                0:       write_match(ufr_pkg::MATCH_CLASS_RESET, ufr_pkg::MATCH_ID_RESET);
                1:       write_match(8'h00, 8'h00);
                2:       write_match(8'hFF, 8'hFF);
                4:       write_match(8'hFF, 8'h00);
                default: write_match(8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
            send_idle_pct = (seg < 2) ? 22 : (seg < 4) ? 53 : 0;
            recv_idle_pct = (seg < 2) ? 53 : (seg < 4) ? 22 : 0;
            // Open some stretches with a boundary-sized good frame
            case (seg)
                1:       forced = MODEL_BYTES + 1;
                2:       forced = PAYLOAD_DEPTH;
                4:       forced = MODEL_BYTES;
                default: forced = 0;
            endcase
            seg_start = rx_sent;
            while (rx_sent - seg_start < 30) begin
                if (forced != 0) begin
                    kind   = SEQ_GOOD;
                    plen   = forced;
                    forced = 0;
                end else begin
                    kind = ($urandom_range(99) < 65) ? SEQ_GOOD :
                           t_seq_kind'($urandom_range(SEQ_TRUNCATED, SEQ_NOISE));
                    plen = pick_len();
                end
                send_sequence(kind, plen);
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ufr_pkg.sv
rtl/core/ubx_frame_receiver_top.sv
sim/ubx_frame_receiver_top_test.sv
